FILE: hw/rtl/ttuv_pkg.sv
package ttuv_pkg;

    // one input beat: a vertex
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
    } t_vtx;

    // one output beat: a copy of the triangle's tangent
    typedef struct packed {
        logic signed [15:0] tan_x;
        logic signed [15:0] tan_y;
        logic signed [15:0] tan_z;
        logic               degenerate;
        logic               last;
    } t_tan;

    localparam int unsigned CORNERS   = 3;
    localparam int unsigned MAG_BITS  = 30;   // reduced magnitudes stay below 2^30
    localparam int unsigned DIV_STEPS = 15;   // quotient bits, value at most 2^14

endpackage

FILE: hw/rtl/triangle_tangent_from_uv_core.sv
// Per-triangle tangent from texture coordinates.
//
// Input channel (i_in_valid / o_in_stall, payload i_vtx): vertices in draw
// order, three to a triangle. The first two corners are held in registers.
// The third starts the computation; o_in_stall stays high until
// the triangle's three result beats have left.
// Output channel (o_out_valid / i_out_stall, payload o_out): the unit
// tangent in Q1.14, sent three times, last set on the third beat. A zero
// uv determinant or a zero direction gives degenerate = 1 and a zero vector.
// After the third corner the core makes eight passes through the shared
// 33x33 multiplier, a check step, a magnitude reduction, three squaring
// passes, 31 square root steps and three divisions; degenerate triangles
// go from the check straight to the output.
// i_out_stall holds the current beat in place and delays the next.
// Reset (synchronous, i_rst_n low) clears the corner count and drops any
// triangle in progress.
module triangle_tangent_from_uv_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ttuv_pkg::t_vtx  i_vtx,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ttuv_pkg::t_tan  o_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_NORM  = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DSET  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam int unsigned MAG_BITS_L = ttuv_pkg::MAG_BITS;

    logic [3:0]         r_state;
    logic [1:0]         r_cc;
    logic signed [31:0] r_hp [6];
    logic signed [23:0] r_ht [4];

    logic signed [24:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic signed [50:0] r_det;
    logic signed [58:0] r_w [3];
    logic [58:0]        r_a [3];
    logic [2:0]         r_neg;
    logic               r_deg;
    logic [4:0]         r_cnt;
    logic [1:0]         r_idx;
    logic [61:0]        r_x, r_res, r_bit;
    logic [46:0]        r_num, r_dsh;
    logic [13:0]        r_q;
    logic signed [15:0] r_t [3];
    logic               r_ov;
    logic [1:0]         r_ecnt;

    logic               in_acc, out_acc;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic [1:0]         widx;
    logic [61:0]        trial;
    logic [30:0]        len;
    logic               big;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_ov && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign widx  = r_cnt[2:1] - 2'd1;
    assign trial = r_res + r_bit;
    assign len   = r_res[30:0];
    assign big   = (|r_a[0][58:MAG_BITS_L]) || (|r_a[1][58:MAG_BITS_L])
                || (|r_a[2][58:MAG_BITS_L]);

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_state == S_SQ) begin
            op_a = {3'b000, r_a[r_idx][29:0]};
            op_b = {3'b000, r_a[r_idx][29:0]};
        end else begin
            unique case (r_cnt[2:0])
                3'd0: begin
                    op_a = {{8{r_du1[24]}}, r_du1};
                    op_b = {{8{r_dv2[24]}}, r_dv2};
                end
                3'd1: begin
                    op_a = {{8{r_du2[24]}}, r_du2};
                    op_b = {{8{r_dv1[24]}}, r_dv1};
                end
                3'd2, 3'd4, 3'd6: begin
                    op_a = {{8{r_dv2[24]}}, r_dv2};
                    op_b = r_e1[widx];
                end
                default: begin
                    op_a = {{8{r_dv1[24]}}, r_dv1};
                    op_b = r_e2[widx];
                end
            endcase
        end
    end
    assign prod = op_a * op_b;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cc    <= 2'd0;
            r_ov    <= 1'b0;
            r_ecnt  <= 2'd0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_cc == 2'd0 || r_cc == 2'd1) begin
                            if (r_cc[0]) begin
                                r_hp[3] <= i_vtx.pos_x;
                                r_hp[4] <= i_vtx.pos_y;
                                r_hp[5] <= i_vtx.pos_z;
                            end else begin
                                r_hp[0] <= i_vtx.pos_x;
                                r_hp[1] <= i_vtx.pos_y;
                                r_hp[2] <= i_vtx.pos_z;
                            end
                            r_ht[{r_cc[0], 1'b0}] <= i_vtx.tex_u;
                            r_ht[{r_cc[0], 1'b1}] <= i_vtx.tex_v;
                            r_cc <= r_cc + 2'd1;
                        end else begin
                            // third corner: edges and uv deltas
                            r_cc  <= 2'd0;
                            r_du1 <= 25'(r_ht[2]) - 25'(r_ht[0]);
                            r_dv1 <= 25'(r_ht[3]) - 25'(r_ht[1]);
                            r_du2 <= 25'(i_vtx.tex_u) - 25'(r_ht[0]);
                            r_dv2 <= 25'(i_vtx.tex_v) - 25'(r_ht[1]);
                            r_e1[0] <= 33'(r_hp[3]) - 33'(r_hp[0]);
                            r_e1[1] <= 33'(r_hp[4]) - 33'(r_hp[1]);
                            r_e1[2] <= 33'(r_hp[5]) - 33'(r_hp[2]);
                            r_e2[0] <= 33'(i_vtx.pos_x) - 33'(r_hp[0]);
                            r_e2[1] <= 33'(i_vtx.pos_y) - 33'(r_hp[1]);
                            r_e2[2] <= 33'(i_vtx.pos_z) - 33'(r_hp[2]);
                            r_cnt   <= '0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // even steps load, odd steps subtract
                    if (r_cnt[2:0] == 3'd0)
                        r_det <= $signed(prod[50:0]);
                    else if (r_cnt[2:0] == 3'd1)
                        r_det <= r_det - $signed(prod[50:0]);
                    else if (!r_cnt[0])
                        r_w[widx] <= $signed(prod[58:0]);
                    else
                        r_w[widx] <= r_w[widx] - $signed(prod[58:0]);
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt[2:0] == 3'd7) r_state <= S_NORM;
                end
                S_NORM: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i]   <= r_w[i][58] ? 59'(-r_w[i]) : 59'(r_w[i]);
                        r_neg[i] <= r_w[i][58] ^ r_det[50];
                    end
                    if (r_det == '0 || (r_w[0] == '0 && r_w[1] == '0 && r_w[2] == '0)) begin
                        r_deg   <= 1'b1;
                        for (int i = 0; i < 3; i++) r_t[i] <= '0;
                        r_ecnt  <= 2'd0;
                        r_ov    <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_deg   <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // common shift until the largest magnitude fits
                    if (big) begin
                        for (int i = 0; i < 3; i++) r_a[i] <= r_a[i] >> 1;
                    end else begin
                        r_x     <= '0;
                        r_idx   <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_x <= r_x + prod[61:0];
                    if (r_idx == 2'd2) begin
                        r_res   <= '0;
                        r_bit   <= 62'd1 << 60;
                        r_state <= S_SQRT;
                    end
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                S_SQRT: begin
                    if (r_x >= trial) begin
                        r_x   <= r_x - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= S_DSET;
                end
                S_DSET: begin
                    r_num   <= {2'b00, r_a[r_idx][29:0], 15'd0} + 47'(len);
                    r_dsh   <= 47'({len, 1'b0}) << (ttuv_pkg::DIV_STEPS - 1);
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_num >= r_dsh) r_num <= r_num - r_dsh;
                    r_q   <= {r_q[12:0], (r_num >= r_dsh)};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ttuv_pkg::DIV_STEPS - 1)) begin
                        r_t[r_idx] <= r_neg[r_idx] ? -$signed({1'b0, r_q[13:0], (r_num >= r_dsh)})
                                                   :  $signed({1'b0, r_q[13:0], (r_num >= r_dsh)});
                        if (r_idx == 2'(ttuv_pkg::CORNERS - 1)) begin
                            r_ecnt  <= 2'd0;
                            r_ov    <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= S_DSET;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (r_ecnt == 2'(ttuv_pkg::CORNERS - 1)) begin
                            r_ov    <= 1'b0;
                            r_state <= S_IDLE;
                        end
                        r_ecnt <= r_ecnt + 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output beat
    assign o_out.tan_x      = r_t[0];
    assign o_out.tan_y      = r_t[1];
    assign o_out.tan_z      = r_t[2];
    assign o_out.degenerate = r_deg;
    assign o_out.last       = (r_ecnt == 2'(ttuv_pkg::CORNERS - 1));

    // checks
    a_no_input_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open while result pending");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.last) |=> !o_out_valid) else $error("beat after last");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.degenerate) |->
        (o_out.tan_x == 16'sd0 && o_out.tan_y == 16'sd0 && o_out.tan_z == 16'sd0))
        else $error("degenerate beat with nonzero tangent");
    a_corner_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc != 2'd3) else $error("corner count out of range");

endmodule
